/* hw/rtl/u16u8_pkg.sv */
// shared types, constants and the code point encoder of the utf-16 to utf-8 unit
`default_nettype none
package u16u8_pkg;

    localparam int CNT_W = 17;
    localparam int UNIT_W = 16;
    localparam int CP_W = 21;
    localparam int BYTE_W = 8;
    localparam int Q_DEPTH = 2;

    localparam logic [CNT_W:0] MAX_LEN = 18'd65536;
    localparam logic [CNT_W-1:0] CAP_RESET = 17'd65536;

    localparam logic [UNIT_W-1:0] HI_SUR_FIRST = 16'hD800;
    localparam logic [UNIT_W-1:0] HI_SUR_LAST = 16'hDBFF;
    localparam logic [UNIT_W-1:0] LO_SUR_FIRST = 16'hDC00;
    localparam logic [UNIT_W-1:0] LO_SUR_LAST = 16'hDFFF;
    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;
    localparam logic [CP_W-1:0] LIM_1B = 21'h000080;
    localparam logic [CP_W-1:0] LIM_2B = 21'h000800;
    localparam logic [CP_W-1:0] LIM_3B = 21'h010000;
    localparam logic [BYTE_W-1:0] LEAD_2B = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_3B = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_4B = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MARK = 8'h80;
    localparam logic [5:0] CONT_MASK = 6'h3F;

    // byte count of one code point and its bytes, byte 0 goes out first
    typedef struct packed {
        logic [2:0] n;
        logic [3:0][BYTE_W-1:0] bytes;
    } enc_t;

    // one queue transaction: up to two code points and an optional summary
    typedef struct packed {
        logic [2:0] a_n;
        logic [3:0][BYTE_W-1:0] a_bytes;
        logic [CNT_W-1:0] a_rc;
        logic [2:0] b_n;
        logic [3:0][BYTE_W-1:0] b_bytes;
        logic [CNT_W-1:0] b_rc;
        logic [CNT_W-1:0] s_rc;
        logic [CNT_W-1:0] wc_base;
        logic summ;
    } q_entry_t;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_S
    } phase_t;

    function automatic enc_t encode_cp(input logic [CP_W-1:0] cp);
        enc_t e;
        e = '0;
        if (cp < LIM_1B) begin
            e.n = 3'd1;
            e.bytes[0] = cp[7:0];
        end
        else if (cp < LIM_2B) begin
            e.n = 3'd2;
            e.bytes[0] = LEAD_2B | {3'd0, cp[10:6]};
            e.bytes[1] = CONT_MARK | {2'd0, cp[5:0] & CONT_MASK};
        end
        else if (cp < LIM_3B) begin
            e.n = 3'd3;
            e.bytes[0] = LEAD_3B | {4'd0, cp[15:12]};
            e.bytes[1] = CONT_MARK | {2'd0, cp[11:6]};
            e.bytes[2] = CONT_MARK | {2'd0, cp[5:0]};
        end
        else begin
            e.n = 3'd4;
            e.bytes[0] = LEAD_4B | {5'd0, cp[20:18]};
            e.bytes[1] = CONT_MARK | {2'd0, cp[17:12]};
            e.bytes[2] = CONT_MARK | {2'd0, cp[11:6]};
            e.bytes[3] = CONT_MARK | {2'd0, cp[5:0]};
        end
        return e;
    endfunction

    // unit count add that sticks at the maximum string length
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                 input logic [1:0] adv);
        logic [CNT_W:0] s;
        s = {1'b0, c} + {{(CNT_W-1){1'b0}}, adv};
        if (s > MAX_LEN) begin
            s = MAX_LEN;
        end
        return s[CNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/u16u8_front.sv */
// front end: takes code units, pairs surrogates, checks capacity, queues work
`default_nettype none
module u16u8_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [u16u8_pkg::CNT_W-1:0]   cfg_cap,
    input  wire logic                          accept,
    input  wire logic [u16u8_pkg::UNIT_W-1:0]  code_unit,
    input  wire logic                          last_unit,
    input  wire logic                          q_full,
    output logic                               push,
    output u16u8_pkg::q_entry_t                push_entry
);

    logic [u16u8_pkg::CNT_W-1:0] cap_reg;
    logic [u16u8_pkg::UNIT_W-1:0] held_reg;
    logic held_valid_reg, held_valid_next;
    logic stopped_reg, stopped_next;
    logic [u16u8_pkg::CNT_W-1:0] rc_reg, rc_next;
    logic [u16u8_pkg::CNT_W-1:0] wc_reg, wc_next;

    logic u_low, u_high, tk_hold;
    logic [u16u8_pkg::CP_W-1:0] tk_cp, a_cp, pair_cp;
    logic [1:0] a_adv;
    logic a_want, b_want, hold_set, a_fit, b_fit, a_emit, b_emit;
    u16u8_pkg::enc_t a_enc, b_enc;
    logic [u16u8_pkg::CNT_W-1:0] rc_a, rc_b, wc_a, wc_b, rc_fin, wc_fin;

    always_comb begin
        u_low = (code_unit >= u16u8_pkg::LO_SUR_FIRST) && (code_unit <= u16u8_pkg::LO_SUR_LAST);
        u_high = (code_unit >= u16u8_pkg::HI_SUR_FIRST) && (code_unit <= u16u8_pkg::HI_SUR_LAST);
        tk_hold = u_high && !last_unit;
        tk_cp = (u_low || u_high) ? u16u8_pkg::REPL_CP : {5'd0, code_unit};
        pair_cp = u16u8_pkg::SUPP_BASE + {1'b0, held_reg[9:0], code_unit[9:0]};

        a_want = 1'b0;
        a_cp = tk_cp;
        a_adv = 2'd1;
        b_want = 1'b0;
        hold_set = 1'b0;
        if (!stopped_reg) begin
            if (held_valid_reg) begin
                if (u_low) begin
                    a_want = 1'b1;
                    a_cp = pair_cp;
                    a_adv = 2'd2;
                end
                else begin
                    // replacement for the held unit; new unit sent or held
                    a_want = 1'b1;
                    a_cp = u16u8_pkg::REPL_CP;
                    b_want = !tk_hold;
                    hold_set = tk_hold;
                end
            end
            else begin
                a_want = !tk_hold;
                hold_set = tk_hold;
            end
        end

        a_enc = u16u8_pkg::encode_cp(a_cp);
        b_enc = u16u8_pkg::encode_cp(tk_cp);
        a_fit = ({1'b0, wc_reg} + {15'd0, a_enc.n}) <= {1'b0, cap_reg};
        a_emit = a_want && a_fit;
        wc_a = wc_reg + {14'd0, a_enc.n};
        rc_a = u16u8_pkg::sat_add(rc_reg, a_adv);
        b_fit = ({1'b0, wc_a} + {15'd0, b_enc.n}) <= {1'b0, cap_reg};
        b_emit = b_want && a_emit && b_fit;
        wc_b = wc_a + {14'd0, b_enc.n};
        rc_b = u16u8_pkg::sat_add(rc_a, 2'd1);

        rc_fin = b_emit ? rc_b : (a_emit ? rc_a : rc_reg);
        wc_fin = b_emit ? wc_b : (a_emit ? wc_a : wc_reg);

        held_valid_next = hold_set && (!held_valid_reg || a_fit);
        stopped_next = stopped_reg || (a_want && !a_fit) || (b_want && a_emit && !b_fit);
        rc_next = rc_fin;
        wc_next = wc_fin;
        if (last_unit) begin
            held_valid_next = 1'b0;
            stopped_next = 1'b0;
            rc_next = '0;
            wc_next = '0;
        end

        push = accept && (a_emit || last_unit);
        push_entry.a_n = a_emit ? a_enc.n : 3'd0;
        push_entry.a_bytes = a_enc.bytes;
        push_entry.a_rc = rc_a;
        push_entry.b_n = b_emit ? b_enc.n : 3'd0;
        push_entry.b_bytes = b_enc.bytes;
        push_entry.b_rc = rc_b;
        push_entry.s_rc = rc_fin;
        push_entry.wc_base = wc_reg;
        push_entry.summ = last_unit;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cap_reg <= u16u8_pkg::CAP_RESET;
            held_valid_reg <= 1'b0;
            stopped_reg <= 1'b0;
            rc_reg <= '0;
            wc_reg <= '0;
        end
        else begin
            if (cfg_we) begin
                cap_reg <= cfg_cap;
            end
            if (accept) begin
                held_valid_reg <= held_valid_next;
                stopped_reg <= stopped_next;
                rc_reg <= rc_next;
                wc_reg <= wc_next;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (accept && held_valid_next) begin
            held_reg <= code_unit;
        end
    end

    // a held high surrogate and a stopped string never coexist
    assert property (@(posedge clk) disable iff (!rst_n) !(held_valid_reg && stopped_reg))
        else $error("held surrogate while stopped");
    assert property (@(posedge clk) disable iff (!rst_n) {1'b0, rc_reg} <= u16u8_pkg::MAX_LEN)
        else $error("unit count past maximum");
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
        else $error("push into full queue");

endmodule
`default_nettype wire

/* hw/rtl/u16u8_queue.sv */
// two-entry queue between the front end and the byte serializer
`default_nettype none
module u16u8_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire u16u8_pkg::q_entry_t  push_entry,
    input  wire logic                 pop,
    output logic                      full,
    output logic                      not_empty,
    output u16u8_pkg::q_entry_t       head
);

    localparam int PTR_W = (u16u8_pkg::Q_DEPTH > 1) ? $clog2(u16u8_pkg::Q_DEPTH) : 1;
    localparam int CNT_QW = $clog2(u16u8_pkg::Q_DEPTH + 1);
    localparam logic [CNT_QW-1:0] DEPTH_C = CNT_QW'(u16u8_pkg::Q_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(u16u8_pkg::Q_DEPTH - 1);

    u16u8_pkg::q_entry_t mem_reg [u16u8_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg, count_next;

    always_comb begin
        full = (count_reg == DEPTH_C);
        not_empty = (count_reg != '0);
        head = mem_reg[rd_ptr_reg];
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

/* hw/rtl/u16u8_back.sv */
// back end: walks a queued transaction and sends one result per cycle while out_stall is low
`default_nettype none
module u16u8_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          not_empty,
    input  wire u16u8_pkg::q_entry_t           head,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [u16u8_pkg::BYTE_W-1:0]       out_byte,
    output logic                               is_byte,
    output logic [u16u8_pkg::CNT_W-1:0]        units_read,
    output logic [u16u8_pkg::CNT_W-1:0]        bytes_written,
    output logic                               end_of_run
);

    u16u8_pkg::phase_t phase_reg, phase_next, eff;
    logic [1:0] idx_reg, idx_next;
    logic out_valid_reg, load;
    logic [u16u8_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic is_byte_reg, is_byte_next;
    logic [u16u8_pkg::CNT_W-1:0] rc_out_reg, rc_out_next, wc_out_reg, wc_out_next;
    logic eor_reg, eor_next;
    logic [3:0] offset;
    logic slot_end;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= u16u8_pkg::PH_A;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (load) begin
                phase_reg <= phase_next;
                idx_reg <= idx_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            byte_reg <= byte_next;
            is_byte_reg <= is_byte_next;
            rc_out_reg <= rc_out_next;
            wc_out_reg <= wc_out_next;
            eor_reg <= eor_next;
        end
    end

    always_comb begin
        load = not_empty && (!out_valid_reg || !out_stall);
        eff = phase_reg;
        if (phase_reg == u16u8_pkg::PH_A && head.a_n == 3'd0) begin
            eff = u16u8_pkg::PH_S;
        end
        phase_next = phase_reg;
        idx_next = idx_reg;
        byte_next = '0;
        is_byte_next = 1'b1;
        rc_out_next = head.s_rc;
        offset = '0;
        eor_next = 1'b0;
        slot_end = 1'b0;
        case (eff)
            u16u8_pkg::PH_A: begin
                byte_next = head.a_bytes[idx_reg];
                rc_out_next = head.a_rc;
                offset = {2'd0, idx_reg} + 4'd1;
                slot_end = ({1'b0, idx_reg} + 3'd1) == head.a_n;
                idx_next = idx_reg + 2'd1;
                if (slot_end) begin
                    idx_next = '0;
                    if (head.b_n != 3'd0) begin
                        phase_next = u16u8_pkg::PH_B;
                    end
                    else if (head.summ) begin
                        phase_next = u16u8_pkg::PH_S;
                    end
                    else begin
                        phase_next = u16u8_pkg::PH_A;
                        eor_next = 1'b1;
                    end
                end
            end
            u16u8_pkg::PH_B: begin
                byte_next = head.b_bytes[idx_reg];
                rc_out_next = head.b_rc;
                offset = {1'b0, head.a_n} + {2'd0, idx_reg} + 4'd1;
                slot_end = ({1'b0, idx_reg} + 3'd1) == head.b_n;
                idx_next = idx_reg + 2'd1;
                if (slot_end) begin
                    idx_next = '0;
                    if (head.summ) begin
                        phase_next = u16u8_pkg::PH_S;
                    end
                    else begin
                        phase_next = u16u8_pkg::PH_A;
                        eor_next = 1'b1;
                    end
                end
            end
            u16u8_pkg::PH_S: begin
                is_byte_next = 1'b0;
                offset = {1'b0, head.a_n} + {1'b0, head.b_n};
                phase_next = u16u8_pkg::PH_A;
                idx_next = '0;
                eor_next = 1'b1;
            end
            default: begin
                phase_next = u16u8_pkg::PH_A;
                idx_next = '0;
            end
        endcase
        wc_out_next = head.wc_base + {13'd0, offset};
        pop = load && eor_next;

        out_valid = out_valid_reg;
        out_byte = byte_reg;
        is_byte = is_byte_reg;
        units_read = rc_out_reg;
        bytes_written = wc_out_reg;
        end_of_run = eor_reg;
    end

    // retiring a transaction always leaves its closing result in the output register
    assert property (@(posedge clk) disable iff (!rst_n) pop |=> out_valid_reg && eor_reg)
        else $error("transaction retired without closing result");
    assert property (@(posedge clk) disable iff (!rst_n)
        load && eff == u16u8_pkg::PH_B |-> head.a_n != 3'd0)
        else $error("second code point without first");

endmodule
`default_nettype wire

/* hw/rtl/utf16_to_utf8_bounded_encoder_unit.sv */
// top level of the utf-16 to utf-8 encoder with destination capacity limit
//
//  channel        direction  handshake                      payload
//  input          in         in_valid / in_stall            code_unit, last_unit
//  result         out        out_valid / out_stall          out_byte, is_byte, units_read,
//                                                           bytes_written, end_of_run
//  capacity cfg   in         dest_capacity_valid / _ready   dest_capacity
//
// a code unit is classified and checked against the capacity in the cycle it is taken
// and what it yields lands in a two-entry queue; the serializer sends one result per
// cycle while out_stall is low: one per utf-8 byte plus one end-of-string summary
// the input stalls only while the queue is full; the result register is the only
// stage that waits on out_stall
// after reset the capacity is 65536 bytes and all string state is clear
`default_nettype none
module utf16_to_utf8_bounded_encoder_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // capacity register write
    input  wire logic                          dest_capacity_valid,
    output logic                               dest_capacity_ready,
    input  wire logic [u16u8_pkg::CNT_W-1:0]   dest_capacity,
    // code units in
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [u16u8_pkg::UNIT_W-1:0]  code_unit,
    input  wire logic                          last_unit,
    // results out
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [u16u8_pkg::BYTE_W-1:0]       out_byte,
    output logic                               is_byte,
    output logic [u16u8_pkg::CNT_W-1:0]        units_read,
    output logic [u16u8_pkg::CNT_W-1:0]        bytes_written,
    output logic                               end_of_run
);

    logic q_full, q_not_empty, push, pop, accept;
    u16u8_pkg::q_entry_t push_entry, head;

    // register writes are always taken
    assign dest_capacity_ready = 1'b1;
    // a transaction is taken whenever the queue has a free slot
    assign in_stall = q_full;
    assign accept = in_valid && !q_full;

    u16u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (dest_capacity_valid),
        .cfg_cap    (dest_capacity),
        .accept     (accept),
        .code_unit  (code_unit),
        .last_unit  (last_unit),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    u16u8_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    u16u8_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .not_empty     (q_not_empty),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .is_byte       (is_byte),
        .units_read    (units_read),
        .bytes_written (bytes_written),
        .end_of_run    (end_of_run)
    );

endmodule
`default_nettype wire

/* tb/sv/utf16_to_utf8_bounded_encoder_unit_tb.sv */
// self-checking testbench of the utf-16 to utf-8 encoder with destination capacity limit
`default_nettype none
module utf16_to_utf8_bounded_encoder_unit_tb;

    // cycles without any transaction before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    // settle time after the last expected result before a capacity write or the end
    localparam int SETTLE_CYCLES = 12;
    // mismatch lines printed before the report goes quiet
    localparam int MAX_REPORTS = 20;
    // a longer string of plain text at the largest capacity
    localparam int LONG_STRING_UNITS = 48;
    localparam int RANDOM_UNITS = 320;
    localparam int unsigned STR_LEN_LIMIT = 65536;
    localparam logic [u16u8_pkg::CNT_W-1:0] CAP_FULL = 17'h1FFFF;

    // one result as seen on the output port
    typedef struct packed {
        logic [u16u8_pkg::BYTE_W-1:0] data;
        logic is_data;
        logic [u16u8_pkg::CNT_W-1:0] units;
        logic [u16u8_pkg::CNT_W-1:0] written;
        logic item_end;
    } utf8_result_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic dest_capacity_valid = 1'b0;
    logic dest_capacity_ready;
    logic [u16u8_pkg::CNT_W-1:0] dest_capacity = '0;

    logic in_valid = 1'b0;
    logic in_stall;
    logic [u16u8_pkg::UNIT_W-1:0] code_unit = '0;
    logic last_unit = 1'b0;

    logic out_valid;
    logic out_stall = 1'b0;
    logic [u16u8_pkg::BYTE_W-1:0] out_byte;
    logic is_byte;
    logic [u16u8_pkg::CNT_W-1:0] units_read;
    logic [u16u8_pkg::CNT_W-1:0] bytes_written;
    logic end_of_run;

    // encoder state as predicted from the accepted transactions
    int unsigned capacity_bytes = 65536;
    int unsigned units_taken = 0;
    int unsigned bytes_emitted = 0;
    logic [u16u8_pkg::UNIT_W-1:0] held_high = '0;
    bit high_pending = 1'b0;
    bit capacity_hit = 1'b0;

    // results predicted and not yet seen on the output
    utf8_result_t encoded_q[$];

    int fail_count = 0;
    int results_seen = 0;
    int units_sent = 0;
    int strings_sent = 0;
    int capacity_writes = 0;
    int burst_left = 0;
    int hang_count = 0;

    stall_mode_t stall_mode = STALL_NONE;
    int stall_left = 0;
    int stall_phase = 0;

    utf16_to_utf8_bounded_encoder_unit DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .dest_capacity_valid (dest_capacity_valid),
        .dest_capacity_ready (dest_capacity_ready),
        .dest_capacity       (dest_capacity),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .code_unit           (code_unit),
        .last_unit           (last_unit),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .out_byte            (out_byte),
        .is_byte             (is_byte),
        .units_read          (units_read),
        .bytes_written       (bytes_written),
        .end_of_run          (end_of_run)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // queue one result carrying the running counters
    task automatic queue_result(input logic [u16u8_pkg::BYTE_W-1:0] data, input logic is_data);
        utf8_result_t r;
        r.data = data;
        r.is_data = is_data;
        r.units = units_taken[u16u8_pkg::CNT_W-1:0];
        r.written = bytes_emitted[u16u8_pkg::CNT_W-1:0];
        r.item_end = 1'b0;
        encoded_q.push_back(r);
    endtask

    // a code point goes out whole or not at all; once it does not fit the
    // rest of the string is dropped
    task automatic encode_code_point(input int unsigned cp, input int unsigned adv,
                                     output bit fit);
        int unsigned n;
        logic [u16u8_pkg::BYTE_W-1:0] seq [4];
        n = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
        fit = (bytes_emitted + n <= capacity_bytes);
        if (!fit)
        begin
            capacity_hit = 1'b1;
        end
        else
        begin
            units_taken += adv;
            if (units_taken > STR_LEN_LIMIT)
            begin
                units_taken = STR_LEN_LIMIT;
            end
            case (n)
                1: seq[0] = 8'(cp);
                2:
                begin
                    seq[0] = 8'hC0 | 8'(cp >> 6);
                    seq[1] = 8'h80 | 8'(cp & 'h3F);
                end
                3:
                begin
                    seq[0] = 8'hE0 | 8'(cp >> 12);
                    seq[1] = 8'h80 | 8'((cp >> 6) & 'h3F);
                    seq[2] = 8'h80 | 8'(cp & 'h3F);
                end
                default:
                begin
                    seq[0] = 8'hF0 | 8'(cp >> 18);
                    seq[1] = 8'h80 | 8'((cp >> 12) & 'h3F);
                    seq[2] = 8'h80 | 8'((cp >> 6) & 'h3F);
                    seq[3] = 8'h80 | 8'(cp & 'h3F);
                end
            endcase
            for (int i = 0; i < int'(n); i++)
            begin
                bytes_emitted++;
                queue_result(seq[i], 1'b1);
            end
        end
    endtask

    task automatic encode_plain_unit(input logic [u16u8_pkg::UNIT_W-1:0] u, input logic is_last);
        bit fit;
        if (u >= u16u8_pkg::HI_SUR_FIRST && u <= u16u8_pkg::HI_SUR_LAST)
        begin
            if (is_last)
            begin
                encode_code_point('hFFFD, 1, fit);
            end
            else
            begin
                held_high = u;
                high_pending = 1'b1;
            end
        end
        else if (u >= u16u8_pkg::LO_SUR_FIRST && u <= u16u8_pkg::LO_SUR_LAST)
        begin
            encode_code_point('hFFFD, 1, fit);
        end
        else
        begin
            encode_code_point(int'(u), 1, fit);
        end
    endtask

    // everything one accepted code unit causes, marking its final result
    task automatic encode_unit(input logic [u16u8_pkg::UNIT_W-1:0] u, input logic is_last);
        int first;
        int unsigned cp;
        bit fit;
        utf8_result_t tail;
        first = encoded_q.size();
        if (!capacity_hit)
        begin
            if (high_pending)
            begin
                high_pending = 1'b0;
                if (u >= u16u8_pkg::LO_SUR_FIRST && u <= u16u8_pkg::LO_SUR_LAST)
                begin
                    cp = 'h10000 + ((int'(held_high) - 'hD800) << 10) + (int'(u) - 'hDC00);
                    encode_code_point(cp, 2, fit);
                end
                else
                begin
                    encode_code_point('hFFFD, 1, fit);
                    if (fit)
                    begin
                        encode_plain_unit(u, is_last);
                    end
                end
            end
            else
            begin
                encode_plain_unit(u, is_last);
            end
        end
        if (is_last)
        begin
            queue_result('0, 1'b0);
            held_high = '0;
            high_pending = 1'b0;
            capacity_hit = 1'b0;
            units_taken = 0;
            bytes_emitted = 0;
        end
        if (encoded_q.size() > first)
        begin
            tail = encoded_q.pop_back();
            tail.item_end = 1'b1;
            encoded_q.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one input transaction; the sender runs in bursts with random gaps and
    // keeps valid high from one transaction to the next inside a burst
    task automatic send_unit(input logic [u16u8_pkg::UNIT_W-1:0] u, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        code_unit <= u;
        last_unit <= is_last;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        encode_unit(u, is_last);
        units_sent++;
        if (is_last)
        begin
            strings_sent++;
        end
    endtask

    // sender holds off until every predicted result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (encoded_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // capacity is only changed between strings with the encoder drained
    task automatic write_capacity(input logic [u16u8_pkg::CNT_W-1:0] value);
        drain_results();
        dest_capacity_valid <= 1'b1;
        dest_capacity <= value;
        do
        begin
            @(posedge clk);
        end
        while (!dest_capacity_ready);
        dest_capacity_valid <= 1'b0;
        capacity_bytes = int'(value);
        capacity_writes++;
    endtask

    task automatic send_string(input logic [u16u8_pkg::UNIT_W-1:0] units [$]);
        foreach (units[i])
        begin
            send_unit(units[i], i == units.size() - 1);
        end
    endtask

    // capacity mix: mostly tight values that cut strings short, plus the extremes
    function automatic logic [u16u8_pkg::CNT_W-1:0] pick_capacity();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 17'd1;
            2: return 17'($urandom_range(2, 8));
            3: return 17'($urandom_range(0, 40));
            4: return u16u8_pkg::CAP_RESET;
            5: return CAP_FULL;
            6: return 17'($urandom_range(0, 131071));
            default: return 17'd3;
        endcase
    endfunction

    function automatic logic [u16u8_pkg::UNIT_W-1:0] pick_three_byte_unit();
        if ($urandom_range(0, 1) == 0)
        begin
            return 16'($urandom_range('h0800, 'hD7FF));
        end
        return 16'($urandom_range('hE000, 'hFFFF));
    endfunction

    // mostly well-formed text with random content, some lone surrogates as noise
    task automatic send_random_string(input int len);
        int i;
        int pick;
        logic [u16u8_pkg::UNIT_W-1:0] u;
        i = 0;
        while (i < len)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                u = 16'($urandom_range(0, 'h7F));
            end
            else if (pick < 50)
            begin
                u = 16'($urandom_range('h80, 'h7FF));
            end
            else if (pick < 70)
            begin
                u = pick_three_byte_unit();
            end
            else if (pick < 88 && i + 1 < len)
            begin
                // well-formed surrogate pair
                send_unit(16'($urandom_range('hD800, 'hDBFF)), 1'b0);
                i++;
                u = 16'($urandom_range('hDC00, 'hDFFF));
            end
            else if (pick < 94)
            begin
                u = 16'($urandom_range('hDC00, 'hDFFF));
            end
            else
            begin
                u = 16'($urandom_range('hD800, 'hDBFF));
            end
            send_unit(u, i == len - 1);
            i++;
            // now and then the sender waits mid-string for the output to drain
            if (i < len && $urandom_range(0, 39) == 0)
            begin
                drain_results();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // boundaries of the 1, 2 and 3 byte forms at the reset capacity
    task automatic test_code_point_sizes();
        logic [u16u8_pkg::UNIT_W-1:0] s [$];
        s = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF,
              16'hE000, 16'hFFFF};
        send_string(s);
        drain_results();
    endtask

    // pairs, lone lows, a held high broken by a plain unit or by another high,
    // and a high surrogate closing the string
    task automatic test_surrogates();
        logic [u16u8_pkg::UNIT_W-1:0] s [$];
        s = '{16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF, 16'hDC00};
        send_string(s);
        s = '{16'hD800, 16'h0041, 16'hD800, 16'hDBFF, 16'hDC00, 16'hDBFF};
        send_string(s);
        drain_results();
    endtask

    // code points that do not fit stop the string, later units are swallowed
    task automatic test_capacity_limit();
        logic [u16u8_pkg::UNIT_W-1:0] s [$];
        write_capacity('0);
        s = '{16'h0041};
        send_string(s);
        write_capacity(17'd1);
        s = '{16'h0041, 16'h0042};
        send_string(s);
        write_capacity(17'd4);
        s = '{16'h20AC, 16'h00E9, 16'h0041};
        send_string(s);
        // the replacement for a broken high does not fit, the next unit is dropped
        write_capacity(17'd2);
        s = '{16'hD800, 16'h0041};
        send_string(s);
        write_capacity(17'd5);
        s = '{16'hDBFF, 16'hDFFF, 16'h0041, 16'h0042};
        send_string(s);
        drain_results();
    endtask

    // a longer string with capacity above 65536
    task automatic test_long_string();
        write_capacity(CAP_FULL);
        for (int i = 0; i < LONG_STRING_UNITS; i++)
        begin
            send_unit(16'($urandom_range(0, 'h7F)), i == LONG_STRING_UNITS - 1);
        end
        drain_results();
    endtask

    task automatic test_random_strings();
        int stop_at;
        stop_at = units_sent + RANDOM_UNITS;
        write_capacity(u16u8_pkg::CAP_RESET);
        while (units_sent < stop_at)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                write_capacity(pick_capacity());
            end
            send_random_string($urandom_range(1, 12));
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // result checking, receiver stall and hang watchdog
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        utf8_result_t got;
        utf8_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{out_byte, is_byte, units_read, bytes_written, end_of_run};
            results_seen++;
            if (encoded_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("%0t unexpected transaction: byte=%h is_byte=%b units=%0d bytes=%0d end=%b",
                             $time, got.data, got.is_data, got.units, got.written,
                             got.item_end);
                end
            end
            else
            begin
                want = encoded_q.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("%0t mismatch: expected byte=%h is_byte=%b units=%0d bytes=%0d end=%b",
                                 $time, want.data, want.is_data, want.units, want.written,
                                 want.item_end);
                        $display("%0t           actual   byte=%h is_byte=%b units=%0d bytes=%0d end=%b",
                                 $time, got.data, got.is_data, got.units, got.written,
                                 got.item_end);
                    end
                end
            end
        end
    end

    // receiver stall follows one of a few patterns, switching every so often
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(64, 256);
        end
        else
        begin
            stall_left--;
        end
        stall_phase = (stall_phase + 1) % 5;
        case (stall_mode)
            STALL_NONE: out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 4) < 3);
            default: out_stall <= (stall_phase < 2);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (dest_capacity_valid && dest_capacity_ready))
        begin
            hang_count = 0;
        end
        else
        begin
            hang_count++;
            if (hang_count >= HANG_LIMIT)
            begin
                $display("%0t no transaction for %0d cycles, %0d results outstanding",
                         $time, HANG_LIMIT, encoded_q.size());
                $display("[utf16_to_utf8_bounded_encoder_unit] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_code_point_sizes();
        test_surrogates();
        test_capacity_limit();
        test_long_string();
        test_random_strings();
        drain_results();
        $display("covered %0d strings, %0d code units, %0d results compared, %0d capacity writes",
                 strings_sent, units_sent, results_seen, capacity_writes);
        $display("including surrogate pairs, lone surrogates and capacity cutoffs");
        if (fail_count == 0)
        begin
            $display("[utf16_to_utf8_bounded_encoder_unit] OK");
        end
        else
        begin
            $display("[utf16_to_utf8_bounded_encoder_unit] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
